FILE: design/second_nearest_distance_macros.svh
// assertion macros for the second nearest distance block
`ifndef SECOND_NEAREST_DISTANCE_MACROS_SVH
`define SECOND_NEAREST_DISTANCE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SND_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SND_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/snd_pkg.sv
// types and constants shared by the second nearest distance modules
package snd_pkg;

  localparam int COORD_BITS = 24;
  localparam int SQ_BITS    = 50;
  localparam int DIST_BITS  = 25;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int SQP_W      = 2 * MAG_W;
  localparam int SUM_W      = SQP_W + 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int ROOT_W     = SQ_BITS;

  localparam logic [SQ_BITS-1:0] SQ_MAX = {SQ_BITS{1'b1}};

  typedef struct packed {
    logic                         first;
    logic                         last;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;
    logic signed [COORD_BITS-1:0] cand_x;
    logic signed [COORD_BITS-1:0] cand_y;
    logic signed [COORD_BITS-1:0] cand_z;
  } item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [SQ_BITS-1:0]   second_sq_distance;
    logic                 too_few;
  } result_t;

  typedef struct packed {
    logic [SQ_BITS-1:0] second_sq;
    logic               too_few;
  } entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_stat_t;

  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                input logic [COORD_BITS-1:0] b);
    logic [MAG_W-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
  endfunction

endpackage

FILE: design/snd_front.sv
// front end: accepts candidates, forms squared distances, tracks the two minimums
module snd_front import snd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  item_t             item,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  q_stat_t           q_stat,
  output logic              busy,
  output logic              push,
  output entry_t            push_data
);

  logic                  three_d;
  logic [COORD_BITS-1:0] hq_x, hq_y, hq_z;
  logic                  accept;

  logic                  p1_valid, p1_first, p1_last;
  logic [MAG_W-1:0]      p1_magx, p1_magy, p1_magz;
  logic                  p2_valid, p2_first, p2_last;
  logic [SQP_W-1:0]      p2_sqx, p2_sqy, p2_sqz;
  logic                  p3_valid, p3_first, p3_last;
  logic [SQ_BITS-1:0]    p3_d;

  logic [SQ_BITS-1:0]    least, second;
  logic [1:0]            seen;

  logic [COORD_BITS-1:0] qx, qy, qz;
  logic [SUM_W-1:0]      sum;
  logic [SQ_BITS-1:0]    d_sat;
  logic [SQ_BITS-1:0]    least_eff, second_eff, least_next, second_next;
  logic [1:0]            seen_eff, seen_next;
  logic [QCNT_W:0]       pending;

  assign accept = start && !busy;

  // lasts still in the pipe or the push register will each need a queue slot
  assign pending = (QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(push)
                 + (QCNT_W+1)'(p1_valid && p1_last)
                 + (QCNT_W+1)'(p2_valid && p2_last) + (QCNT_W+1)'(p3_valid && p3_last);
  assign busy = pending >= (QCNT_W+1)'(QDEPTH);

  assign qx = item.first ? item.query_x : hq_x;
  assign qy = item.first ? item.query_y : hq_y;
  assign qz = item.first ? item.query_z : hq_z;

  assign sum = SUM_W'(p2_sqx) + SUM_W'(p2_sqy) + (three_d ? SUM_W'(p2_sqz) : '0);
  assign d_sat = (sum > SUM_W'(SQ_MAX)) ? SQ_MAX : sum[SQ_BITS-1:0];

  always_comb begin
    least_eff  = p3_first ? SQ_MAX : least;
    second_eff = p3_first ? SQ_MAX : second;
    seen_eff   = p3_first ? 2'd0 : seen;
    least_next  = least_eff;
    second_next = second_eff;
    if (p3_d < least_eff) begin
      second_next = least_eff;
      least_next  = p3_d;
    end else if (p3_d < second_eff) begin
      second_next = p3_d;
    end
    seen_next = (seen_eff < 2'd2) ? seen_eff + 2'd1 : seen_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      three_d  <= 1'b0;
      hq_x     <= '0;
      hq_y     <= '0;
      hq_z     <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      least    <= SQ_MAX;
      second   <= SQ_MAX;
      seen     <= 2'd0;
      push     <= 1'b0;
    end else begin
      if (cfg_write) begin
        three_d <= cfg_data;
      end
      if (accept && item.first) begin
        hq_x <= item.query_x;
        hq_y <= item.query_y;
        hq_z <= item.query_z;
      end
      p1_valid <= accept;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      push     <= 1'b0;
      if (p3_valid) begin
        if (p3_last) begin
          least  <= SQ_MAX;
          second <= SQ_MAX;
          seen   <= 2'd0;
          push   <= 1'b1;
        end else begin
          least  <= least_next;
          second <= second_next;
          seen   <= seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_first <= item.first;
    p1_last  <= item.last;
    p1_magx  <= abs_diff(qx, item.cand_x);
    p1_magy  <= abs_diff(qy, item.cand_y);
    p1_magz  <= abs_diff(qz, item.cand_z);
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_sqx   <= SQP_W'(p1_magx) * SQP_W'(p1_magx);
    p2_sqy   <= SQP_W'(p1_magy) * SQP_W'(p1_magy);
    p2_sqz   <= SQP_W'(p1_magz) * SQP_W'(p1_magz);
    p3_first <= p2_first;
    p3_last  <= p2_last;
    p3_d     <= d_sat;
    if (seen_next < 2'd2) begin
      push_data.second_sq <= '0;
      push_data.too_few   <= 1'b1;
    end else begin
      push_data.second_sq <= second_next;
      push_data.too_few   <= 1'b0;
    end
  end

endmodule

FILE: design/snd_queue.sv
// small fifo of finished runs between front and back
module snd_queue import snd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_data,
  input  logic    pop,
  output entry_t  pop_data,
  output q_stat_t stat
);

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] head, tail;
  logic [QCNT_W-1:0] count;

  assign pop_data   = mem[head];
  assign stat.count = count;
  assign stat.empty = count == '0;
  assign stat.full  = count == QCNT_W'(QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + QPTR_W'(1);
      end
      if (pop) begin
        head <= head + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

FILE: design/snd_back.sv
// back end: bit-pair square root of each queued run, then the result strobe
module snd_back import snd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_stat_t q_stat,
  input  entry_t  pop_data,
  output logic    pop,
  output logic    done,
  output result_t result
);

  typedef enum logic {IDLE, ROOT} state_t;

  state_t             state;
  logic [SQ_BITS-1:0] rem, bitpos, sq_hold;
  logic [ROOT_W-1:0]  root;
  logic               few_hold;
  logic [SQ_BITS-1:0] trial;
  logic [SQ_BITS-1:0] rem_next;
  logic [ROOT_W-1:0]  root_next;

  assign pop = (state == IDLE) && !q_stat.empty;

  always_comb begin
    trial     = SQ_BITS'(root) + bitpos;
    rem_next  = rem;
    root_next = root >> 1;
    if (rem >= trial) begin
      rem_next  = rem - trial;
      root_next = (root >> 1) + ROOT_W'(bitpos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (pop) begin
            state    <= ROOT;
            rem      <= pop_data.second_sq;
            sq_hold  <= pop_data.second_sq;
            few_hold <= pop_data.too_few;
            root     <= '0;
            bitpos   <= SQ_BITS'(1) << (SQ_BITS - 2);
          end
        end
        ROOT: begin
          rem    <= rem_next;
          root   <= root_next;
          bitpos <= bitpos >> 2;
          if (bitpos[0]) begin
            state                     <= IDLE;
            done                      <= 1'b1;
            result.distance           <= root_next[DIST_BITS-1:0];
            result.second_sq_distance <= sq_hold;
            result.too_few            <= few_hold;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/second_nearest_distance.sv
// top level of the second nearest distance block
//
//   channel   direction  handshake             payload
//   item      in         start, busy           item (item_t)
//   result    out        done                  result (result_t)
//   config    in         cfg_write             cfg_data (three_d)
//
// one candidate per cycle while busy is low; busy rises when the run queue plus
// runs still in the three-stage distance pipe and the push register would fill
// its four slots.
// with the root loop free, a run's result strobe follows its last accepted candidate
// through the three pipe stages, the push register, the queue and the shared square
// root loop (pop, then one step per bit pair).
// runs that end while the root loop is still busy wait in the queue.
// synchronous reset clears pipe, queue, run state, held query and three_d.
module second_nearest_distance import snd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  input  logic    cfg_write,
  input  logic    cfg_data,
  output logic    done,
  output result_t result
);

  logic    push, pop;
  entry_t  push_data, pop_data;
  q_stat_t q_stat;

  snd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  snd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  snd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .done     (done),
    .result   (result)
  );

`include "second_nearest_distance_macros.svh"

  `SND_ASSERT_NOW(a_no_overflow, push, !q_stat.full || pop, "queue push while full")
  `SND_ASSERT_NOW(a_no_underflow, pop, !q_stat.empty, "queue pop while empty")
  `SND_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `SND_ASSERT_NOW(a_few_zero, done && result.too_few,
                  result.distance == '0 && result.second_sq_distance == '0,
                  "short run with nonzero result")

endmodule
